@@ src/ctp_pkg.sv @@
// shared types, constants and the arctangent table of the cartesian to polar converter
package ctp_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int MAG_W       = 20;
	localparam int HEAD_W      = 17;

	// sum of squares, then 8 extra bits so the root carries 4 fraction bits
	localparam int SQ_W      = 2 * COORD_WIDTH;
	localparam int ROOT_N_W  = SQ_W + 8;
	localparam int ROOT_BITS = ROOT_N_W / 2;

	// cordic datapath: inputs scaled so the largest vector sits near bit 38
	localparam int CORDIC_SHIFT = 38 - COORD_WIDTH;
	localparam int CX_W         = 40;
	localparam int Z_W          = 25;

	localparam int ATAN_LEN = 24;
	localparam int ATAN_W   = 22;

	localparam int RDEG_W = 22;
	localparam logic [RDEG_W-1:0] RAD_TO_DEG_Q16 = 22'd3754936;
	localparam int NUM_W = CX_W + RDEG_W;

	// quotient width of the residual angle divide: 26 - iterations, never below 8
	localparam int QUO_SPAN = 26;
	localparam int QUO_MIN  = 8;

	localparam int ZC_W      = 23;
	localparam int FRAC_DROP = 8;
	localparam int TQ_W      = ZC_W - FRAC_DROP;
	localparam logic [ZC_W-1:0] QUARTER_Q16 = 23'd5898240;
	localparam logic [ZC_W-1:0] Q8_HALF     = 23'd128;

	localparam logic [HEAD_W-1:0] HALF_TURN_Q8 = 17'd46080;
	localparam logic [HEAD_W-1:0] FULL_TURN_Q8 = 17'd92160;
	localparam logic [MAG_W-1:0]  MAG_MAX      = '1;

	// atan(2^-i) in degrees, 16 fraction bits
	localparam logic [ATAN_W-1:0] ATAN_TAB [0:ATAN_LEN-1] = '{
		22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
		22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
		22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
		22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
	};

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x_coord;
		logic signed [COORD_WIDTH-1:0] y_coord;
	} coord_t;

	typedef struct packed {
		logic [MAG_W-1:0]  magnitude;
		logic [HEAD_W-1:0] heading;
	} polar_t;

	typedef struct packed {
		logic x_neg;
		logic y_neg;
		logic is_zero;
	} quad_t;

	typedef struct packed {
		logic signed [CX_W-1:0] cx;
		logic signed [CX_W-1:0] cy;
		logic signed [Z_W-1:0]  z;
	} cordic_t;

	typedef struct packed {
		logic signed [CX_W-1:0] den;
		logic signed [Z_W-1:0]  z;
		logic                   neg;
		logic                   den_pos;
	} div_ctx_t;

endpackage

@@ src/ctp_cordic_cell.sv @@
// one vectoring micro-rotation of the cordic chain
module ctp_cordic_cell import ctp_pkg::*; #(
	parameter int unsigned STEP = 0
) (
	input  logic    clk,
	input  logic    en,
	input  cordic_t cor_in,
	output cordic_t cor_s1
);

	localparam logic signed [Z_W-1:0] ANG = signed'(Z_W'(ATAN_TAB[STEP]));

	// shift toward zero, same magnitude for either sign
	function automatic logic signed [CX_W-1:0] shr_sym(input logic signed [CX_W-1:0] v);
		logic [CX_W-1:0] mag;
		logic [CX_W-1:0] res;
		mag = v[CX_W-1] ? (~v + 1'b1) : v;
		res = mag >> STEP;
		return v[CX_W-1] ? -signed'(res) : signed'(res);
	endfunction

	logic signed [CX_W-1:0] dx;
	logic signed [CX_W-1:0] dy;
	cordic_t                cor_nx;

	always_comb begin
		dx = shr_sym(cor_in.cy);
		dy = shr_sym(cor_in.cx);
		if (!cor_in.cy[CX_W-1]) begin
			cor_nx.cx = cor_in.cx + dx;
			cor_nx.cy = cor_in.cy - dy;
			cor_nx.z  = cor_in.z + ANG;
		end else begin
			cor_nx.cx = cor_in.cx - dx;
			cor_nx.cy = cor_in.cy + dy;
			cor_nx.z  = cor_in.z - ANG;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cor_s1 <= cor_nx;
		end
	end

endmodule

@@ src/ctp_sqrt_cell.sv @@
// one result bit of the restoring square root chain
module ctp_sqrt_cell import ctp_pkg::*; #(
	parameter int unsigned BIT = 0
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [ROOT_N_W-1:0]  rem_in,
	input  logic [ROOT_BITS-1:0] root_in,
	output logic [ROOT_N_W-1:0]  rem_s1,
	output logic [ROOT_BITS-1:0] root_s1
);

	logic [ROOT_N_W:0]    trial;
	logic                 fits;
	logic [ROOT_N_W-1:0]  rem_nx;
	logic [ROOT_BITS-1:0] root_nx;

	always_comb begin
		// (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b); the two terms never share a bit
		trial   = ((ROOT_N_W + 1)'(root_in) << (BIT + 1)) | ((ROOT_N_W + 1)'(1) << (2 * BIT));
		fits    = {1'b0, rem_in} >= trial;
		rem_nx  = fits ? (rem_in - trial[ROOT_N_W-1:0]) : rem_in;
		root_nx = fits ? (root_in | (ROOT_BITS'(1) << BIT)) : root_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1  <= rem_nx;
			root_s1 <= root_nx;
		end
	end

endmodule

@@ src/ctp_div_cell.sv @@
// one quotient bit of the residual angle divide
module ctp_div_cell import ctp_pkg::*; #(
	parameter int unsigned QW  = 10,
	parameter int unsigned BIT = 0
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] rem_in,
	input  logic [QW-1:0]    quo_in,
	input  div_ctx_t         ctx_in,
	output logic [NUM_W-1:0] rem_s1,
	output logic [QW-1:0]    quo_s1,
	output div_ctx_t         ctx_s1
);

	logic [NUM_W-1:0] trial;
	logic             fits;

	always_comb begin
		trial = NUM_W'($unsigned(ctx_in.den)) << BIT;
		fits  = rem_in >= trial;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= fits ? (rem_in - trial) : rem_in;
			quo_s1 <= fits ? (quo_in | (QW'(1) << BIT)) : quo_in;
			ctx_s1 <= ctx_in;
		end
	end

endmodule

@@ src/cartesian_to_polar_degrees_top.sv @@
// top level of the cartesian to polar converter: front end, cell chains and output buffer
//
// Converts a signed (x_coord, y_coord) vector to its length (4 fraction bits) and its
// heading in degrees (8 fraction bits, 0 up to under 360), one beat per clock while the input
// is not stalled. Each beat runs down a chain of cells: ITERATIONS cordic rotation cells, one
// constant multiply, max(26 - ITERATIONS, 8) divider cells that turn the leftover angle into
// degrees, and a parallel chain of 20 square root cells for the length. The output side holds
// up to two finished results, so the input is stalled only once both are waiting.
module cartesian_to_polar_degrees_top import ctp_pkg::*; #(
	parameter int ITERATIONS = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   coord_valid,
	output logic   coord_stall,
	input  coord_t coord,
	output logic   polar_valid,
	input  logic   polar_stall,
	output polar_t polar
);

	localparam int QUO_BITS   = (QUO_SPAN - ITERATIONS > QUO_MIN) ? QUO_SPAN - ITERATIONS : QUO_MIN;
	localparam int ANG_STAGES = ITERATIONS + 1 + QUO_BITS + 2;
	localparam int MAG_DELAY  = ANG_STAGES - (ROOT_BITS + 1);
	localparam int TOTAL      = 3 + ANG_STAGES;

	logic adv;
	logic take;
	logic tail_vld;
	logic vld_q [0:TOTAL-1];
	logic out_vld_q;
	logic skid_vld_q;

	// front end
	logic [COORD_WIDTH-1:0] ax_nx, ay_nx;
	logic [COORD_WIDTH-1:0] ax_s1, ay_s1, ax_s2, ay_s2;
	quad_t                  quad_s1, quad_s2, quad_s3;
	logic [SQ_W-1:0]        sqx_s2, sqy_s2;
	logic [ROOT_N_W-1:0]    n_s3;
	cordic_t                cor_s3;

	assign adv = !skid_vld_q;

	always_comb begin
		ax_nx = coord.x_coord[COORD_WIDTH-1] ? (~coord.x_coord + 1'b1) : coord.x_coord;
		ay_nx = coord.y_coord[COORD_WIDTH-1] ? (~coord.y_coord + 1'b1) : coord.y_coord;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1           <= ax_nx;
			ay_s1           <= ay_nx;
			quad_s1.x_neg   <= coord.x_coord[COORD_WIDTH-1];
			quad_s1.y_neg   <= coord.y_coord[COORD_WIDTH-1];
			quad_s1.is_zero <= (coord.x_coord == '0) && (coord.y_coord == '0);

			sqx_s2  <= SQ_W'(ax_s1) * SQ_W'(ax_s1);
			sqy_s2  <= SQ_W'(ay_s1) * SQ_W'(ay_s1);
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
			quad_s2 <= quad_s1;

			// the sum of squares tops out at 2^(2*COORD_WIDTH-1), no overflow
			n_s3     <= {sqx_s2 + sqy_s2, 8'b0};
			cor_s3.cx <= signed'(CX_W'(ax_s2) << CORDIC_SHIFT);
			cor_s3.cy <= signed'(CX_W'(ay_s2) << CORDIC_SHIFT);
			cor_s3.z  <= '0;
			quad_s3  <= quad_s2;
		end
	end

	// square root chain
	logic [ROOT_N_W-1:0]  sq_rem  [0:ROOT_BITS];
	logic [ROOT_BITS-1:0] sq_root [0:ROOT_BITS];

	assign sq_rem[0]  = n_s3;
	assign sq_root[0] = '0;

	for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
		ctp_sqrt_cell #(
			.BIT(ROOT_BITS - 1 - k)
		) u_cell (
			.clk    (clk),
			.en     (adv),
			.rem_in (sq_rem[k]),
			.root_in(sq_root[k]),
			.rem_s1 (sq_rem[k+1]),
			.root_s1(sq_root[k+1])
		);
	end

	logic [MAG_W-1:0]  mag_rnd_q;
	logic [MAG_W-1:0]  mag_dly_q [0:MAG_DELAY-1];
	logic [MAG_W:0]    root_up;
	logic [MAG_W-1:0]  mag_nx;

	always_comb begin
		root_up = (MAG_W + 1)'(sq_root[ROOT_BITS]) + 1'b1;
		// remainder above the root means the exact root is past the half step
		if (sq_rem[ROOT_BITS] > ROOT_N_W'(sq_root[ROOT_BITS])) begin
			mag_nx = (root_up > (MAG_W + 1)'(MAG_MAX)) ? MAG_MAX : root_up[MAG_W-1:0];
		end else begin
			mag_nx = MAG_W'(sq_root[ROOT_BITS]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_rnd_q    <= mag_nx;
			mag_dly_q[0] <= mag_rnd_q;
			for (int j = 1; j < MAG_DELAY; j++) begin
				mag_dly_q[j] <= mag_dly_q[j-1];
			end
		end
	end

	// cordic chain
	cordic_t cor_chain [0:ITERATIONS];

	assign cor_chain[0] = cor_s3;

	for (genvar k = 0; k < ITERATIONS; k++) begin : g_cordic
		ctp_cordic_cell #(
			.STEP(k)
		) u_cell (
			.clk   (clk),
			.en    (adv),
			.cor_in(cor_chain[k]),
			.cor_s1(cor_chain[k+1])
		);
	end

	// residual angle: cy / cx scaled to degrees
	logic [CX_W-1:0]  cy_mag;
	logic [NUM_W-1:0] num_nx;
	logic [NUM_W-1:0] num_q;
	div_ctx_t         ctx_nx;
	div_ctx_t         ctx_q;

	always_comb begin
		cy_mag         = cor_chain[ITERATIONS].cy[CX_W-1] ?
			(~cor_chain[ITERATIONS].cy + 1'b1) : cor_chain[ITERATIONS].cy;
		num_nx         = cy_mag * RAD_TO_DEG_Q16;
		ctx_nx.den     = cor_chain[ITERATIONS].cx;
		ctx_nx.z       = cor_chain[ITERATIONS].z;
		ctx_nx.neg     = cor_chain[ITERATIONS].cy[CX_W-1];
		ctx_nx.den_pos = !cor_chain[ITERATIONS].cx[CX_W-1] && (cor_chain[ITERATIONS].cx != '0);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_q <= num_nx;
			ctx_q <= ctx_nx;
		end
	end

	logic [NUM_W-1:0]    div_rem [0:QUO_BITS];
	logic [QUO_BITS-1:0] div_quo [0:QUO_BITS];
	div_ctx_t            div_ctx [0:QUO_BITS];

	assign div_rem[0] = num_q;
	assign div_quo[0] = '0;
	assign div_ctx[0] = ctx_q;

	for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
		ctp_div_cell #(
			.QW (QUO_BITS),
			.BIT(QUO_BITS - 1 - k)
		) u_cell (
			.clk   (clk),
			.en    (adv),
			.rem_in(div_rem[k]),
			.quo_in(div_quo[k]),
			.ctx_in(div_ctx[k]),
			.rem_s1(div_rem[k+1]),
			.quo_s1(div_quo[k+1]),
			.ctx_s1(div_ctx[k+1])
		);
	end

	// quadrant flags ride along the angle path
	quad_t quad_dly_q [0:ANG_STAGES-2];

	always_ff @(posedge clk) begin
		if (adv) begin
			quad_dly_q[0] <= quad_s3;
			for (int j = 1; j < ANG_STAGES - 1; j++) begin
				quad_dly_q[j] <= quad_dly_q[j-1];
			end
		end
	end

	// clamp to the first quadrant and round to 8 fraction bits
	logic signed [Z_W:0] qv;
	logic signed [Z_W:0] zsum;
	logic [ZC_W-1:0]     zc;
	logic [ZC_W-1:0]     zr;
	logic [TQ_W-1:0]     tq_q;

	always_comb begin
		qv = signed'((Z_W + 1)'(div_quo[QUO_BITS]));
		if (div_ctx[QUO_BITS].neg) begin
			qv = -qv;
		end
		if (!div_ctx[QUO_BITS].den_pos) begin
			qv = '0;
		end
		zsum = (Z_W + 1)'(div_ctx[QUO_BITS].z) + qv;
		if (zsum[Z_W]) begin
			zc = '0;
		end else if (zsum > (Z_W + 1)'(QUARTER_Q16)) begin
			zc = QUARTER_Q16;
		end else begin
			zc = zsum[ZC_W-1:0];
		end
		zr = zc + Q8_HALF;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tq_q <= zr[ZC_W-1:FRAC_DROP];
		end
	end

	// unfold into the full turn
	quad_t             quad_f;
	logic [HEAD_W-1:0] head_nx;
	logic [HEAD_W-1:0] head_q;

	always_comb begin
		quad_f = quad_dly_q[ANG_STAGES-2];
		if (!quad_f.x_neg && !quad_f.y_neg) begin
			head_nx = HEAD_W'(tq_q);
		end else if (quad_f.x_neg && !quad_f.y_neg) begin
			head_nx = HALF_TURN_Q8 - HEAD_W'(tq_q);
		end else if (quad_f.x_neg) begin
			head_nx = HALF_TURN_Q8 + HEAD_W'(tq_q);
		end else begin
			head_nx = FULL_TURN_Q8 - HEAD_W'(tq_q);
		end
		if (head_nx >= FULL_TURN_Q8) begin
			head_nx = head_nx - FULL_TURN_Q8;
		end
		if (quad_f.is_zero) begin
			head_nx = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			head_q <= head_nx;
		end
	end

	// valid line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TOTAL; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_q[0] <= coord_valid;
			for (int i = 1; i < TOTAL; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// output register plus skid buffer
	polar_t out_q;
	polar_t skid_q;
	polar_t tail;
	logic   load_out;
	logic   load_skid;

	assign tail_vld       = vld_q[TOTAL-1];
	assign tail.magnitude = mag_dly_q[MAG_DELAY-1];
	assign tail.heading   = head_q;
	assign take           = out_vld_q && !polar_stall;
	assign load_out       = skid_vld_q ? take : (tail_vld && (!out_vld_q || take));
	assign load_skid      = !skid_vld_q && tail_vld && out_vld_q && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (take) begin
				skid_vld_q <= 1'b0;
			end
		end else if (tail_vld) begin
			if (!out_vld_q || take) begin
				out_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end else if (take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= skid_vld_q ? skid_q : tail;
		end
		if (load_skid) begin
			skid_q <= tail;
		end
	end

	assign coord_stall = skid_vld_q;
	assign polar_valid = out_vld_q;
	assign polar       = out_q;

`ifndef ASSERT_OFF
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid buffer holds a beat while the output register is empty");

	a_skid_catches: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && polar_stall && tail_vld && !skid_vld_q) |=> skid_vld_q)
		else $error("finished beat dropped while the output was stalled");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_vld_q && !polar_stall) |=> (!skid_vld_q && out_vld_q))
		else $error("skid buffer did not drain into the output register");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (out_q.heading < FULL_TURN_Q8))
		else $error("heading outside one full turn");
`endif

endmodule
